FILE: design/assert_macros.svh
// assertion helpers shared by the rtl
// PECG_ASSERT is gated off while reset is low, PECG_ASSERT_RST also checks reset behavior
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define PECG_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

`define PECG_ASSERT_RST(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

FILE: design/pecg_pkg.sv
// ----------------------------------------------------------------------------
// pecg_pkg
// types, constants and elaboration-time helpers for the peak envelope gain block
// ----------------------------------------------------------------------------
`default_nettype none

package pecg_pkg;

    localparam int FIELD_COUNT   = 4;
    localparam int MAX_CHANNELS  = 4;
    localparam int SAMPLE_W      = 24;
    localparam int LANES_W       = 3;
    localparam int GAIN_W        = 17;
    localparam int COEF_W        = 16;
    localparam int CFG_DATA_W    = 17;
    localparam int CFG_IDX_W     = 2;
    localparam int CURVE_DEPTH_DEF = 1024;
    localparam int CORDIC_STEPS  = 24;

    localparam int LANE_LIMIT_I =
        (MAX_CHANNELS < FIELD_COUNT) ? MAX_CHANNELS : FIELD_COUNT;
    localparam logic [LANES_W-1:0] LANE_LIMIT = LANES_W'(LANE_LIMIT_I);

    localparam logic [GAIN_W-1:0]  UNITY       = 17'd65536;
    localparam logic [LANES_W-1:0] LANES_RST   = 3'd2;
    localparam logic [GAIN_W-1:0]  BLEND_RST   = 17'd65536;
    localparam logic [COEF_W-1:0]  ATTACK_RST  = 16'd58982;
    localparam logic [COEF_W-1:0]  RELEASE_RST = 16'd65503;

    localparam int SAMPLE_MAX_I = 8388607;
    localparam int SAMPLE_MIN_I = -8388608;

    // register map
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ACTIVE_CHANNELS,
        CFG_CURVE_BLEND,
        CFG_ATTACK_COEFF,
        CFG_RELEASE_COEFF
    } t_cfg_idx;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample_0;
        logic signed [SAMPLE_W-1:0] sample_1;
        logic signed [SAMPLE_W-1:0] sample_2;
        logic signed [SAMPLE_W-1:0] sample_3;
    } t_in_item;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] out_0;
        logic signed [SAMPLE_W-1:0] out_1;
        logic signed [SAMPLE_W-1:0] out_2;
        logic signed [SAMPLE_W-1:0] out_3;
    } t_out_item;

    // atan(2^-i) in q2.30
    localparam longint ATAN_Q30 [CORDIC_STEPS] = '{
        843314856, 497837829, 263043836, 133525158, 67021686, 33543515,
        16775850, 8388437, 4194282, 2097149, 1048575, 524287,
        262143, 131071, 65535, 32767, 16383, 8191,
        4095, 2047, 1023, 511, 255, 127
    };

    function automatic longint shr_tz(input longint v, input int s);
        return (v < 0) ? -((-v) >>> s) : (v >>> s);
    endfunction

    // vectoring-mode cordic angle, used only to build the curve rom
    function automatic longint cordic_angle(input longint x0, input longint y0);
        longint x;
        longint y;
        longint z;
        longint dx;
        longint dy;
        x = x0 <<< 20;
        y = y0 <<< 20;
        z = 0;
        for (int i = 0; i < CORDIC_STEPS; i++) begin
            dx = shr_tz(y, i);
            dy = shr_tz(x, i);
            if (y >= 0) begin
                x = x + dx;
                y = y - dy;
                z = z + ATAN_Q30[i];
            end else begin
                x = x - dx;
                y = y + dy;
                z = z - ATAN_Q30[i];
            end
        end
        return z;
    endfunction

endpackage

`default_nettype wire

FILE: design/peak_envelope_curve_gain.sv
// ----------------------------------------------------------------------------
// peak_envelope_curve_gain
// peak envelope follower with a soft atan curve driving a smoothed frame gain
// ----------------------------------------------------------------------------
// Each request is one frame of four Q1.23 samples. The block takes the peak
// magnitude over the active channels, runs it through a one-pole envelope
// follower (attack pole on a rising peak, release pole otherwise), maps the
// envelope through a normalized atan curve held in a ROM of
// CURVE_TABLE_DEPTH+1 entries with linear interpolation, blends that with
// unity, and smooths the result into a running gain (attack pole when the
// gain falls). Each active channel comes out as sample times gain, rounded
// and saturated; inactive channels come out as zero. From acceptance to the
// result register a frame makes one pass of the 21-step
// microprogram that drives a single shared 25x18 multiply-accumulate and one
// ROM read port, seventeen straight steps, then a two-step multiply and
// writeback pair run once for each of the four channels, then the finish
// step. The input is ready again from the edge that parks the result in the
// output register, so a frame is taken only once the last is through; the
// last step waits only if the previous result has not been taken yet.
// Configuration is written through a plain write port and should change only
// between frames.
`default_nettype none

`include "assert_macros.svh"

module peak_envelope_curve_gain #(
    parameter int CURVE_TABLE_DEPTH = pecg_pkg::CURVE_DEPTH_DEF
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    // input frames
    input  wire logic                                i_in_valid,
    output logic                                     o_in_ready,
    input  wire pecg_pkg::t_in_item                  i_in,
    // result frames
    output logic                                     o_out_valid,
    input  wire logic                                i_out_ready,
    output pecg_pkg::t_out_item                      o_out,
    // configuration writes
    input  wire logic                                i_cfg_we,
    input  wire logic [pecg_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  wire logic [pecg_pkg::CFG_DATA_W-1:0]     i_cfg_data
);
    import pecg_pkg::*;

    // ------------------------------------------------------------------------
    // curve rom, built at elaboration
    // ------------------------------------------------------------------------
    localparam int D      = CURVE_TABLE_DEPTH;
    localparam int ROM_W  = GAIN_W;
    localparam int IDX_W  = $clog2(D + 1);
    localparam int ENV_W  = SAMPLE_W;
    localparam int FRAC_W = SAMPLE_W - 1;
    localparam int POS_W  = ENV_W + IDX_W;

    // full-scale angle, used as the normalizing divisor
    localparam longint CurveTopRaw = cordic_angle(longint'(100 * D), longint'(401 * D));
    localparam longint CurveTop    = (CurveTopRaw <= 0) ? longint'(1) : CurveTopRaw;

    function automatic logic [(CURVE_TABLE_DEPTH+1)*GAIN_W-1:0] build_curve();
        logic [(CURVE_TABLE_DEPTH+1)*GAIN_W-1:0] rom;
        longint a;
        longint v;
        longint prev;
        rom  = '0;
        prev = 0;
        for (int k = 0; k <= CURVE_TABLE_DEPTH; k++) begin
            a = cordic_angle(longint'(100 * CURVE_TABLE_DEPTH),
                             longint'(400 * k + CURVE_TABLE_DEPTH));
            if (a < 0) begin
                a = 0;
            end
            v = (a * 65536 + CurveTop / 2) / CurveTop;
            if (v > 65536) begin
                v = 65536;
            end
            // keep the curve monotonic
            if (k > 0 && v < prev) begin
                v = prev;
            end
            rom[k*GAIN_W +: GAIN_W] = GAIN_W'(v);
            prev = v;
        end
        return rom;
    endfunction

    localparam logic [(D+1)*ROM_W-1:0] CURVE_ROM = build_curve();

    // ------------------------------------------------------------------------
    // datapath widths and constants
    // ------------------------------------------------------------------------
    localparam int A_W   = SAMPLE_W + 1;
    localparam int B_W   = GAIN_W + 1;
    localparam int MUL_W = A_W + B_W;
    localparam int ACC_W = MUL_W + 1;
    localparam int Q_W   = ACC_W - 16;
    localparam int CH_W  = (FIELD_COUNT > 1) ? $clog2(FIELD_COUNT) : 1;

    localparam logic signed [ACC_W-1:0] RND16 = ACC_W'(32768);
    localparam logic signed [ACC_W-1:0] RND23 = ACC_W'(4194304);
    localparam logic signed [Q_W-1:0]   Q_MAX = Q_W'(SAMPLE_MAX_I);
    localparam logic signed [Q_W-1:0]   Q_MIN = Q_W'(SAMPLE_MIN_I);
    localparam logic [CH_W-1:0]         CH_LAST = CH_W'(FIELD_COUNT - 1);
    localparam logic [IDX_W-1:0]        IDX_TOP = IDX_W'(D);

    // ------------------------------------------------------------------------
    // microcode
    // ------------------------------------------------------------------------
    localparam int PC_W = 5;

    typedef enum logic [3:0] {
        OP_NOP,
        OP_PEAK,        // latch peak magnitude over active lanes
        OP_COEF_ENV,    // pick pole for the envelope
        OP_ENV_WB,      // envelope <- acc >> 16
        OP_ADDR,        // rom index and fraction from envelope
        OP_RD_LO,       // rom read at index
        OP_RD_HI,       // rom read at index + 1, held at the top entry
        OP_CURVE_WB,    // curve <- lo + interpolation
        OP_TGT_WB,      // blended target <- acc >> 16
        OP_COEF_GAIN,   // pick pole for the gain
        OP_GAIN_WB,     // gain <- acc >> 16
        OP_OUT_WB,      // one channel result, saturated
        OP_FINISH       // park frame in output register
    } t_op;

    typedef enum logic [2:0] {
        A_ENV, A_PEAK, A_FRAC, A_CURVE, A_UNITY, A_GAIN, A_TGT, A_SAMPLE
    } t_asel;

    typedef enum logic [2:0] {
        B_COEF, B_COEF_C, B_DIFF, B_BLEND, B_BLEND_C, B_GAIN
    } t_bsel;

    typedef enum logic [1:0] {
        ACC_HOLD, ACC_RND16, ACC_RND23, ACC_ADD
    } t_accm;

    typedef enum logic [2:0] {
        J_NEXT, J_JUMP, J_WAIT_IN, J_CH_LOOP, J_WAIT_OUT
    } t_jmp;

    typedef struct packed {
        t_op              op;
        t_asel            a;
        t_bsel            b;
        t_accm            acc;
        t_jmp             jmp;
        logic [PC_W-1:0]  tgt;
    } t_uop;

    localparam logic [PC_W-1:0] PC_IDLE       = 5'd0;
    localparam logic [PC_W-1:0] PC_PEAK       = 5'd1;
    localparam logic [PC_W-1:0] PC_COEF_ENV   = 5'd2;
    localparam logic [PC_W-1:0] PC_ENV_MUL_S  = 5'd3;
    localparam logic [PC_W-1:0] PC_ENV_MUL_X  = 5'd4;
    localparam logic [PC_W-1:0] PC_ENV_WB     = 5'd5;
    localparam logic [PC_W-1:0] PC_ADDR       = 5'd6;
    localparam logic [PC_W-1:0] PC_RD_LO      = 5'd7;
    localparam logic [PC_W-1:0] PC_RD_HI      = 5'd8;
    localparam logic [PC_W-1:0] PC_INTERP     = 5'd9;
    localparam logic [PC_W-1:0] PC_CURVE_WB   = 5'd10;
    localparam logic [PC_W-1:0] PC_BLEND_C    = 5'd11;
    localparam logic [PC_W-1:0] PC_BLEND_U    = 5'd12;
    localparam logic [PC_W-1:0] PC_TGT_WB     = 5'd13;
    localparam logic [PC_W-1:0] PC_COEF_GAIN  = 5'd14;
    localparam logic [PC_W-1:0] PC_GAIN_MUL_S = 5'd15;
    localparam logic [PC_W-1:0] PC_GAIN_MUL_X = 5'd16;
    localparam logic [PC_W-1:0] PC_GAIN_WB    = 5'd17;
    localparam logic [PC_W-1:0] PC_OUT_MUL    = 5'd18;
    localparam logic [PC_W-1:0] PC_OUT_WB     = 5'd19;
    localparam logic [PC_W-1:0] PC_FINISH     = 5'd20;

    // the program: one control word per step
    function automatic t_uop ucode(input logic [PC_W-1:0] pc);
        t_uop u;
        unique case (pc)
            PC_IDLE:       u = '{OP_NOP,       A_ENV,    B_COEF,    ACC_HOLD,  J_WAIT_IN,  PC_PEAK};
            PC_PEAK:       u = '{OP_PEAK,      A_ENV,    B_COEF,    ACC_HOLD,  J_NEXT,     PC_IDLE};
            PC_COEF_ENV:   u = '{OP_COEF_ENV,  A_ENV,    B_COEF,    ACC_HOLD,  J_NEXT,     PC_IDLE};
            PC_ENV_MUL_S:  u = '{OP_NOP,       A_ENV,    B_COEF,    ACC_RND16, J_NEXT,     PC_IDLE};
            PC_ENV_MUL_X:  u = '{OP_NOP,       A_PEAK,   B_COEF_C,  ACC_ADD,   J_NEXT,     PC_IDLE};
            PC_ENV_WB:     u = '{OP_ENV_WB,    A_ENV,    B_COEF,    ACC_HOLD,  J_NEXT,     PC_IDLE};
            PC_ADDR:       u = '{OP_ADDR,      A_ENV,    B_COEF,    ACC_HOLD,  J_NEXT,     PC_IDLE};
            PC_RD_LO:      u = '{OP_RD_LO,     A_ENV,    B_COEF,    ACC_HOLD,  J_NEXT,     PC_IDLE};
            PC_RD_HI:      u = '{OP_RD_HI,     A_ENV,    B_COEF,    ACC_HOLD,  J_NEXT,     PC_IDLE};
            PC_INTERP:     u = '{OP_NOP,       A_FRAC,   B_DIFF,    ACC_RND23, J_NEXT,     PC_IDLE};
            PC_CURVE_WB:   u = '{OP_CURVE_WB,  A_ENV,    B_COEF,    ACC_HOLD,  J_NEXT,     PC_IDLE};
            PC_BLEND_C:    u = '{OP_NOP,       A_CURVE,  B_BLEND,   ACC_RND16, J_NEXT,     PC_IDLE};
            PC_BLEND_U:    u = '{OP_NOP,       A_UNITY,  B_BLEND_C, ACC_ADD,   J_NEXT,     PC_IDLE};
            PC_TGT_WB:     u = '{OP_TGT_WB,    A_ENV,    B_COEF,    ACC_HOLD,  J_NEXT,     PC_IDLE};
            PC_COEF_GAIN:  u = '{OP_COEF_GAIN, A_ENV,    B_COEF,    ACC_HOLD,  J_NEXT,     PC_IDLE};
            PC_GAIN_MUL_S: u = '{OP_NOP,       A_GAIN,   B_COEF,    ACC_RND16, J_NEXT,     PC_IDLE};
            PC_GAIN_MUL_X: u = '{OP_NOP,       A_TGT,    B_COEF_C,  ACC_ADD,   J_NEXT,     PC_IDLE};
            PC_GAIN_WB:    u = '{OP_GAIN_WB,   A_ENV,    B_COEF,    ACC_HOLD,  J_NEXT,     PC_IDLE};
            PC_OUT_MUL:    u = '{OP_NOP,       A_SAMPLE, B_GAIN,    ACC_RND16, J_NEXT,     PC_IDLE};
            PC_OUT_WB:     u = '{OP_OUT_WB,    A_ENV,    B_COEF,    ACC_HOLD,  J_CH_LOOP,  PC_OUT_MUL};
            PC_FINISH:     u = '{OP_FINISH,    A_ENV,    B_COEF,    ACC_HOLD,  J_WAIT_OUT, PC_IDLE};
            default:       u = '{OP_NOP,       A_ENV,    B_COEF,    ACC_HOLD,  J_JUMP,     PC_IDLE};
        endcase
        return u;
    endfunction

    // ------------------------------------------------------------------------
    // registers
    // ------------------------------------------------------------------------
    // sequencer and handshake
    logic [PC_W-1:0]            r_pc;
    logic [PC_W-1:0]            n_pc;
    logic [CH_W-1:0]            r_ch;
    logic                       r_out_valid;
    t_out_item                  r_out;

    // configuration
    logic [LANES_W-1:0]         r_cfg_lanes;
    logic [GAIN_W-1:0]          r_cfg_blend;
    logic [COEF_W-1:0]          r_cfg_atk;
    logic [COEF_W-1:0]          r_cfg_rel;

    // follower state
    logic [ENV_W-1:0]           r_env;
    logic [GAIN_W-1:0]          r_gain;

    // working registers
    logic signed [SAMPLE_W-1:0] r_smp [FIELD_COUNT];
    logic signed [SAMPLE_W-1:0] r_res [FIELD_COUNT];
    logic [ENV_W-1:0]           r_peak;
    logic [COEF_W-1:0]          r_coef;
    logic [IDX_W-1:0]           r_idx;
    logic [FRAC_W-1:0]          r_frac;
    logic [ROM_W-1:0]           r_lo;
    logic [ROM_W-1:0]           r_hi;
    logic [GAIN_W-1:0]          r_curve;
    logic [GAIN_W-1:0]          r_tgt;
    logic signed [ACC_W-1:0]    r_acc;

    // ------------------------------------------------------------------------
    // combinational datapath
    // ------------------------------------------------------------------------
    t_uop                       uop;
    logic                       in_acc;
    logic                       out_free;
    logic [LANES_W-1:0]         lanes;
    logic [ENV_W-1:0]           mag [FIELD_COUNT];
    logic [ENV_W-1:0]           peak;
    logic [GAIN_W-1:0]          blend;
    logic [GAIN_W-1:0]          coef_c;
    logic [POS_W-1:0]           pos;
    logic [IDX_W-1:0]           hi_addr;
    logic [IDX_W-1:0]           rd_addr;
    logic [ROM_W-1:0]           rom_q;
    logic signed [A_W-1:0]      a_op;
    logic signed [B_W-1:0]      b_op;
    logic signed [MUL_W-1:0]    mul;
    logic signed [ACC_W-1:0]    acc_base;
    logic signed [Q_W-1:0]      acc_q;
    logic signed [SAMPLE_W-1:0] sat;
    logic                       ch_active;

    assign uop         = ucode(r_pc);
    assign o_in_ready  = (r_pc == PC_IDLE);
    assign in_acc      = i_in_valid && o_in_ready;
    assign out_free    = !r_out_valid || i_out_ready;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    // lane count: zero acts as one, clamp to what exists
    always_comb begin
        priority if (r_cfg_lanes == '0) begin
            lanes = LANES_W'(1);
        end else if (r_cfg_lanes > LANE_LIMIT) begin
            lanes = LANE_LIMIT;
        end else begin
            lanes = r_cfg_lanes;
        end
    end

    // magnitudes, full-scale negative gives 2^23
    always_comb begin
        for (int c = 0; c < FIELD_COUNT; c++) begin
            mag[c] = r_smp[c][SAMPLE_W-1] ? ENV_W'(~r_smp[c] + 1'b1) : ENV_W'(r_smp[c]);
        end
    end

    always_comb begin
        peak = '0;
        for (int c = 0; c < FIELD_COUNT; c++) begin
            if (LANES_W'(c) < lanes && mag[c] > peak) begin
                peak = mag[c];
            end
        end
    end

    assign blend  = (r_cfg_blend > UNITY) ? UNITY : r_cfg_blend;
    assign coef_c = UNITY - GAIN_W'(r_coef);

    // curve position: integer part indexes the rom, the rest weights it
    assign pos     = POS_W'(r_env) * POS_W'(D);
    assign hi_addr = (r_idx == IDX_TOP) ? r_idx : r_idx + 1'b1;
    assign rd_addr = (uop.op == OP_RD_HI) ? hi_addr : r_idx;
    assign rom_q   = CURVE_ROM[rd_addr * ROM_W +: ROM_W];

    // shared multiplier operands
    always_comb begin
        unique case (uop.a)
            A_ENV:    a_op = $signed({1'b0, r_env});
            A_PEAK:   a_op = $signed({1'b0, r_peak});
            A_FRAC:   a_op = $signed({2'b00, r_frac});
            A_CURVE:  a_op = $signed(A_W'(r_curve));
            A_UNITY:  a_op = $signed(A_W'(UNITY));
            A_GAIN:   a_op = $signed(A_W'(r_gain));
            A_TGT:    a_op = $signed(A_W'(r_tgt));
            A_SAMPLE: a_op = A_W'(r_smp[r_ch]);
            default:  a_op = '0;
        endcase
    end

    always_comb begin
        unique case (uop.b)
            B_COEF:    b_op = $signed(B_W'(r_coef));
            B_COEF_C:  b_op = $signed({1'b0, coef_c});
            B_DIFF:    b_op = $signed({1'b0, r_hi - r_lo});
            B_BLEND:   b_op = $signed({1'b0, blend});
            B_BLEND_C: b_op = $signed({1'b0, UNITY - blend});
            B_GAIN:    b_op = $signed({1'b0, r_gain});
            default:   b_op = '0;
        endcase
    end

    assign mul = a_op * b_op;

    always_comb begin
        unique case (uop.acc)
            ACC_RND16: acc_base = RND16;
            ACC_RND23: acc_base = RND23;
            ACC_ADD:   acc_base = r_acc;
            default:   acc_base = '0;
        endcase
    end

    // output rounding adds a half then floor shifts, then saturate to q1.23
    assign acc_q = r_acc[ACC_W-1:16];
    always_comb begin
        priority if (acc_q > Q_MAX) begin
            sat = SAMPLE_W'(Q_MAX);
        end else if (acc_q < Q_MIN) begin
            sat = SAMPLE_W'(Q_MIN);
        end else begin
            sat = acc_q[SAMPLE_W-1:0];
        end
    end

    assign ch_active = LANES_W'(r_ch) < lanes;

    // ------------------------------------------------------------------------
    // step sequencing
    // ------------------------------------------------------------------------
    always_comb begin
        unique case (uop.jmp)
            J_NEXT:     n_pc = r_pc + 1'b1;
            J_JUMP:     n_pc = uop.tgt;
            J_WAIT_IN:  n_pc = in_acc ? uop.tgt : r_pc;
            J_CH_LOOP:  n_pc = (r_ch != CH_LAST) ? uop.tgt : r_pc + 1'b1;
            J_WAIT_OUT: n_pc = out_free ? uop.tgt : r_pc;
            default:    n_pc = PC_IDLE;
        endcase
    end

    // control, configuration, follower state and the output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc        <= PC_IDLE;
            r_ch        <= '0;
            r_out_valid <= 1'b0;
            r_cfg_lanes <= LANES_RST;
            r_cfg_blend <= BLEND_RST;
            r_cfg_atk   <= ATTACK_RST;
            r_cfg_rel   <= RELEASE_RST;
            r_env       <= '0;
            r_gain      <= UNITY;
        end else begin
            r_pc <= n_pc;

            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_ACTIVE_CHANNELS: r_cfg_lanes <= i_cfg_data[LANES_W-1:0];
                    CFG_CURVE_BLEND:     r_cfg_blend <= i_cfg_data[GAIN_W-1:0];
                    CFG_ATTACK_COEFF:    r_cfg_atk   <= i_cfg_data[COEF_W-1:0];
                    CFG_RELEASE_COEFF:   r_cfg_rel   <= i_cfg_data[COEF_W-1:0];
                endcase
            end

            if (uop.op == OP_ENV_WB) begin
                r_env <= r_acc[16 +: ENV_W];
            end
            if (uop.op == OP_GAIN_WB) begin
                r_gain <= r_acc[16 +: GAIN_W];
            end

            // channel counter walks the output loop and rests at zero
            if (uop.jmp == J_CH_LOOP) begin
                r_ch <= (r_ch != CH_LAST) ? r_ch + 1'b1 : '0;
            end

            if (uop.op == OP_FINISH && out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end

        // result payload needs no reset
        if (uop.op == OP_FINISH && out_free) begin
            r_out.out_0 <= r_res[0];
            r_out.out_1 <= r_res[1];
            r_out.out_2 <= r_res[2];
            r_out.out_3 <= r_res[3];
        end
    end

    // working datapath registers
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_smp[0] <= i_in.sample_0;
            r_smp[1] <= i_in.sample_1;
            r_smp[2] <= i_in.sample_2;
            r_smp[3] <= i_in.sample_3;
        end

        if (uop.acc != ACC_HOLD) begin
            r_acc <= acc_base + ACC_W'(mul);
        end

        unique case (uop.op)
            OP_PEAK:      r_peak <= peak;
            OP_COEF_ENV:  r_coef <= (r_peak > r_env) ? r_cfg_atk : r_cfg_rel;
            OP_ADDR: begin
                r_idx  <= pos[FRAC_W +: IDX_W];
                r_frac <= pos[FRAC_W-1:0];
            end
            OP_RD_LO:     r_lo <= rom_q;
            OP_RD_HI:     r_hi <= rom_q;
            OP_CURVE_WB:  r_curve <= r_lo + r_acc[FRAC_W +: GAIN_W];
            OP_TGT_WB:    r_tgt <= r_acc[16 +: GAIN_W];
            OP_COEF_GAIN: r_coef <= (r_tgt < r_gain) ? r_cfg_atk : r_cfg_rel;
            OP_OUT_WB:    r_res[r_ch] <= ch_active ? sat : '0;
            default: begin
            end
        endcase
    end

    // ------------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------------
    // after reset the sequencer waits for a frame with nothing pending
    `PECG_ASSERT_RST(a_reset_idle, !i_rst_n |=> (o_in_ready && !o_out_valid), "reset did not idle")
    // an accepted frame starts the program at its first step
    `PECG_ASSERT(a_start, (i_in_valid && o_in_ready) |=> (r_pc == PC_PEAK), "frame did not start")
    // the channel loop always leaves its counter at zero
    `PECG_ASSERT(a_ch_rest, o_in_ready |-> (r_ch == '0), "channel counter not at rest")
    // the smoothed gain never goes above unity
    `PECG_ASSERT(a_gain_max, (r_pc == PC_GAIN_WB) |=> (r_gain <= UNITY), "gain above unity")
    // a finished frame lands in the output register and frees the input
    `PECG_ASSERT(a_finish, (r_pc == PC_FINISH && out_free) |=> (o_out_valid && o_in_ready), "frame not delivered")

endmodule

`default_nettype wire

FILE: tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the peak envelope curve gain block
// ----------------------------------------------------------------------------
// Frames go in over a valid/ready request channel with random gaps, and result
// frames come back under random back-pressure. A behavioral model of the
// envelope follower, the interpolated atan curve and the gain smoother
// predicts every result frame, which is compared lane by lane with the oldest
// prediction. Directed tests cover the reset settings, the channel-count
// clamps, full-scale negative samples, the blend and pole extremes. The random
// part walks the envelope over the whole curve while the register settings
// change between phases.
// ----------------------------------------------------------------------------

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CURVE_D       = pecg_pkg::CURVE_DEPTH_DEF;
    localparam int LANE_CAP      = pecg_pkg::LANE_LIMIT_I;
    localparam int SETTLE_CYCLES = 30;
    localparam int MAX_IDLE      = 15;
    localparam int RANDOM_FRAMES = 1100;
    localparam int MAX_REPORTS   = 10;
    localparam int RUN_LIMIT_NS  = 2_000_000;
    localparam longint ONE_Q16   = 65536;
    localparam int SAT_HI        = pecg_pkg::SAMPLE_MAX_I;
    localparam int SAT_LO        = pecg_pkg::SAMPLE_MIN_I;

    // atan(2^-i) in q2.30, one entry per cordic step
    localparam longint ATAN_STEP [24] = '{
        843314856, 497837829, 263043836, 133525158, 67021686, 33543515,
        16775850, 8388437, 4194282, 2097149, 1048575, 524287,
        262143, 131071, 65535, 32767, 16383, 8191,
        4095, 2047, 1023, 511, 255, 127
    };

    // ------------------------------------------------------------------
    // clock, reset and block ports
    // ------------------------------------------------------------------
    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    logic                 in_valid = 1'b0;
    logic                 in_ready;
    pecg_pkg::t_in_item   in_frame = '0;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    pecg_pkg::t_out_item  out_frame;
    logic                 cfg_we = 1'b0;
    logic [pecg_pkg::CFG_IDX_W-1:0]  cfg_idx  = '0;
    logic [pecg_pkg::CFG_DATA_W-1:0] cfg_data = '0;

    always begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    peak_envelope_curve_gain #(
        .CURVE_TABLE_DEPTH (CURVE_D)
    ) i_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in        (in_frame),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out       (out_frame),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_data  (cfg_data)
    );

    // ------------------------------------------------------------------
    // predictor state: register copies, envelope, gain and the curve table
    // ------------------------------------------------------------------
    longint lanes_reg   = pecg_pkg::LANES_RST;
    longint blend_reg   = pecg_pkg::BLEND_RST;
    longint attack_reg  = pecg_pkg::ATTACK_RST;
    longint release_reg = pecg_pkg::RELEASE_RST;
    longint env_level   = 0;
    longint gain_q16    = ONE_Q16;
    longint curve_tbl [0:CURVE_D];

    pecg_pkg::t_out_item expected_frames [$];

    bit tx_idle_on = 1'b1;
    bit rx_idle_on = 1'b1;
    int stall_left = 0;
    int frames_sent = 0;
    int results_checked = 0;
    int mismatch_count = 0;
    int settings_used = 0;

    // shift right rounding toward zero, as the curve builder does for negatives
    function automatic longint shift_toward_zero(input longint v, input int s);
        if (v < 0)
            return -((-v) >>> s);
        return v >>> s;
    endfunction

    // integer cordic in vectoring mode, returns the angle in q2.30
    function automatic longint cordic_vector_angle(input longint x0, input longint y0);
        longint x;
        longint y;
        longint z;
        longint dx;
        longint dy;
        x = x0 <<< 20;
        y = y0 <<< 20;
        z = 0;
        for (int i = 0; i < 24; i++) begin
            dx = shift_toward_zero(y, i);
            dy = shift_toward_zero(x, i);
            if (y >= 0) begin
                x = x + dx;
                y = y - dy;
                z = z + ATAN_STEP[i];
            end else begin
                x = x - dx;
                y = y + dy;
                z = z - ATAN_STEP[i];
            end
        end
        return z;
    endfunction

    // normalized atan(4e+0.01) curve, forced monotonic
    function automatic void build_curve_table();
        longint top;
        longint ang;
        longint v;
        top = cordic_vector_angle(100 * CURVE_D, 401 * CURVE_D);
        if (top <= 0)
            top = 1;
        for (int k = 0; k <= CURVE_D; k++) begin
            ang = cordic_vector_angle(100 * CURVE_D, 400 * longint'(k) + CURVE_D);
            if (ang < 0)
                ang = 0;
            v = (ang * ONE_Q16 + top / 2) / top;
            if (v > ONE_Q16)
                v = ONE_Q16;
            if (k > 0 && v < curve_tbl[k-1])
                v = curve_tbl[k-1];
            curve_tbl[k] = v;
        end
    endfunction

    // linear interpolation between table entries, envelope scaled by depth
    function automatic longint curve_gain_at(input longint env);
        longint pos;
        longint idx;
        longint frac;
        pos  = env * CURVE_D;
        idx  = pos >>> 23;
        frac = pos & 64'h7F_FFFF;
        if (idx >= CURVE_D)
            return curve_tbl[CURVE_D];
        return curve_tbl[idx] +
            (((curve_tbl[idx+1] - curve_tbl[idx]) * frac + 64'h40_0000) >>> 23);
    endfunction

    function automatic longint pole_step(input longint st, input longint x, input longint a);
        return (st * a + x * (ONE_Q16 - a) + 32768) >>> 16;
    endfunction

    // advances envelope and gain by one frame and returns the scaled frame
    function automatic pecg_pkg::t_out_item predict_output_frame(
        input pecg_pkg::t_in_item f
    );
        longint samp [4];
        longint scaled [4];
        longint lanes;
        longint peak;
        longint mag;
        longint blend;
        longint target;
        pecg_pkg::t_out_item r;
        samp[0] = f.sample_0;
        samp[1] = f.sample_1;
        samp[2] = f.sample_2;
        samp[3] = f.sample_3;
        lanes = lanes_reg;
        if (lanes < 1)
            lanes = 1;
        if (lanes > LANE_CAP)
            lanes = LANE_CAP;
        peak = 0;
        for (int ch = 0; ch < lanes; ch++) begin
            mag = (samp[ch] < 0) ? -samp[ch] : samp[ch];
            if (mag > peak)
                peak = mag;
        end
        env_level = pole_step(env_level, peak, (peak > env_level) ? attack_reg : release_reg);
        blend  = (blend_reg > ONE_Q16) ? ONE_Q16 : blend_reg;
        target = (blend * curve_gain_at(env_level) + (ONE_Q16 - blend) * ONE_Q16 + 32768)
            >>> 16;
        gain_q16 = pole_step(gain_q16, target, (target < gain_q16) ? attack_reg : release_reg);
        for (int ch = 0; ch < 4; ch++) begin
            scaled[ch] = 0;
            if (ch < lanes) begin
                scaled[ch] = (samp[ch] * gain_q16 + 32768) >>> 16;
                if (scaled[ch] > SAT_HI)
                    scaled[ch] = SAT_HI;
                if (scaled[ch] < SAT_LO)
                    scaled[ch] = SAT_LO;
            end
        end
        r.out_0 = scaled[0][23:0];
        r.out_1 = scaled[1][23:0];
        r.out_2 = scaled[2][23:0];
        r.out_3 = scaled[3][23:0];
        return r;
    endfunction

    function automatic logic signed [23:0] lane_of(input pecg_pkg::t_out_item v, input int ch);
        case (ch)
            0: return v.out_0;
            1: return v.out_1;
            2: return v.out_2;
            default: return v.out_3;
        endcase
    endfunction

    function automatic pecg_pkg::t_in_item mk_frame(input int s0, input int s1,
                                                     input int s2, input int s3);
        pecg_pkg::t_in_item f;
        f.sample_0 = s0[23:0];
        f.sample_1 = s1[23:0];
        f.sample_2 = s2[23:0];
        f.sample_3 = s3[23:0];
        return f;
    endfunction

    // ------------------------------------------------------------------
    // result side: random stall once a result shows up, then check it
    // ------------------------------------------------------------------
    always @(posedge clk) begin : rx_stall
        int unsigned n;
        if (!rst_n) begin
            out_ready  <= 1'b0;
            stall_left <= 0;
        end else if (out_ready) begin
            if (out_valid) begin
                // next result is held off with ready low for a random stall
                n = rx_idle_on ? $urandom_range(0, MAX_IDLE) : 0;
                if (n != 0) begin
                    out_ready  <= 1'b0;
                    stall_left <= n;
                end
            end
        end else if (stall_left == 0 || (out_valid && stall_left == 1)) begin
            out_ready <= 1'b1;
        end else if (out_valid) begin
            stall_left <= stall_left - 1;
        end
    end

    always @(posedge clk) begin : result_check
        pecg_pkg::t_out_item want;
        if (rst_n && out_valid === 1'b1 && out_ready) begin
            if (expected_frames.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS)
                    $display("result frame with no request pending: %h", out_frame);
            end else begin
                want = expected_frames.pop_front();
                for (int ch = 0; ch < 4; ch++) begin
                    if (lane_of(out_frame, ch) !== lane_of(want, ch)) begin
                        mismatch_count++;
                        if (mismatch_count <= MAX_REPORTS)
                            $display("frame %0d lane %0d: expected %0d, got %0d",
                                     results_checked, ch, lane_of(want, ch),
                                     lane_of(out_frame, ch));
                    end
                end
                results_checked++;
            end
        end
    end

    // ------------------------------------------------------------------
    // shared sender tasks
    // ------------------------------------------------------------------

    // one request: optional gap with valid low, then hold until accepted
    task automatic send_frame(input pecg_pkg::t_in_item f);
        int gap;
        gap = tx_idle_on ? $urandom_range(0, MAX_IDLE) : 0;
        if (gap != 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_frame <= f;
        do @(posedge clk); while (!in_ready);
        expected_frames.push_back(predict_output_frame(f));
        frames_sent++;
    endtask

    // stop sending and wait for every pending result, then the requested extra idle cycles
    task automatic settle_block(input int extra);
        in_valid <= 1'b0;
        @(posedge clk);
        while (expected_frames.size() != 0)
            @(posedge clk);
        repeat (extra) @(posedge clk);
    endtask

    task automatic write_reg(input pecg_pkg::t_cfg_idx idx,
                             input logic [pecg_pkg::CFG_DATA_W-1:0] value);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= value;
        @(posedge clk);
    endtask

    // registers only change with the block idle
    task automatic apply_settings(input longint lanes, input longint blend,
                                  input longint atk, input longint rel);
        settle_block(SETTLE_CYCLES);
        write_reg(pecg_pkg::CFG_ACTIVE_CHANNELS, 17'(lanes));
        write_reg(pecg_pkg::CFG_CURVE_BLEND,     17'(blend));
        write_reg(pecg_pkg::CFG_ATTACK_COEFF,    17'(atk));
        write_reg(pecg_pkg::CFG_RELEASE_COEFF,   17'(rel));
        cfg_we      <= 1'b0;
        lanes_reg   = lanes & 7;
        blend_reg   = blend & 17'h1_FFFF;
        attack_reg  = atk & 16'hFFFF;
        release_reg = rel & 16'hFFFF;
        settings_used++;
        @(posedge clk);
    endtask

    // random sample up to 2^scale in magnitude, now and then an extreme value
    function automatic int random_sample(input int scale);
        logic [31:0] v;
        v = $urandom;
        case ($urandom_range(0, 31))
            0: return SAT_HI;
            1: return SAT_LO;
            2: return 0;
            3: return -1;
            default: return $signed(v[23:0]) >>> (23 - scale);
        endcase
    endfunction

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // reset settings, no register writes yet
    task automatic test_default_frames();
        send_frame(mk_frame(0, 0, 0, 0));
        send_frame(mk_frame(SAT_HI, SAT_HI, SAT_HI, SAT_HI));
        send_frame(mk_frame(SAT_LO, SAT_LO, SAT_LO, SAT_LO));
        send_frame(mk_frame(1, -1, SAT_HI, SAT_LO));
        send_frame(mk_frame(-1, 1, 0, 0));
    endtask

    // lane count zero acts as one, above four clamps, unused lanes give zero
    task automatic test_lane_clamps();
        for (int n = 0; n < 8; n++) begin
            apply_settings(n, ONE_Q16, pecg_pkg::ATTACK_RST, pecg_pkg::RELEASE_RST);
            send_frame(mk_frame(SAT_LO, 4000000, -3000000, SAT_HI));
        end
    endtask

    // full-scale negative magnitude drives the peak
    task automatic test_full_scale_negative();
        apply_settings(4, ONE_Q16, 0, 0);
        send_frame(mk_frame(SAT_LO, SAT_LO, SAT_LO, SAT_LO));
        send_frame(mk_frame(0, 100, -100, SAT_LO));
    endtask

    // blend off, just over unity and at the top of the field
    task automatic test_blend_extremes();
        apply_settings(4, 0, 0, 0);
        send_frame(mk_frame(SAT_HI, -5000000, 0, 1));
        apply_settings(4, ONE_Q16 + 1, 0, 0);
        send_frame(mk_frame(SAT_HI, -5000000, 0, 1));
        apply_settings(4, 17'h1_FFFF, 0, 0);
        send_frame(mk_frame(-2000000, 3000000, SAT_LO, 7));
    endtask

    // poles at both ends: frozen state and instant tracking
    task automatic test_pole_extremes();
        apply_settings(3, ONE_Q16, 16'hFFFF, 16'hFFFF);
        send_frame(mk_frame(SAT_HI, SAT_LO, SAT_HI, 0));
        send_frame(mk_frame(10, -10, 0, 0));
        apply_settings(3, ONE_Q16, 0, 0);
        send_frame(mk_frame(SAT_HI, SAT_LO, SAT_HI, 0));
        send_frame(mk_frame(10, -10, 0, 0));
        apply_settings(4, 32768, 0, 16'hFFFF);
        send_frame(mk_frame(6000000, 0, -6000000, 123));
        send_frame(mk_frame(0, 0, 0, 0));
    endtask

    // phases of random settings, each a series of level segments
    task automatic test_random_program();
        int sent;
        int phase_len;
        int seg_left;
        int scale [4];
        longint blend;
        longint atk;
        longint rel;
        sent = 0;
        seg_left = 0;
        while (sent < RANDOM_FRAMES) begin
            case ($urandom_range(0, 3))
                0: blend = 0;
                1: blend = ONE_Q16;
                2: blend = $urandom_range(65537, 131071);
                default: blend = $urandom_range(0, 65536);
            endcase
            case ($urandom_range(0, 4))
                0: atk = 0;
                1: atk = 16'hFFFF;
                2: atk = $urandom_range(0, 65535);
                default: atk = $urandom_range(40000, 62000);
            endcase
            case ($urandom_range(0, 4))
                0: rel = 0;
                1: rel = 16'hFFFF;
                2: rel = $urandom_range(0, 65535);
                default: rel = $urandom_range(55000, 65500);
            endcase
            apply_settings($urandom_range(0, 7), blend, atk, rel);
            // some phases run back to back on both sides
            tx_idle_on = ($urandom_range(0, 3) != 0);
            rx_idle_on = ($urandom_range(0, 3) != 0);
            phase_len = $urandom_range(40, 160);
            for (int i = 0; i < phase_len; i++) begin
                if (seg_left == 0) begin
                    // new level: loud, quiet or silent stretch per lane
                    seg_left = $urandom_range(1, 30);
                    for (int ch = 0; ch < 4; ch++)
                        scale[ch] = $urandom_range(0, 23);
                end
                send_frame(mk_frame(random_sample(scale[0]), random_sample(scale[1]),
                                    random_sample(scale[2]), random_sample(scale[3])));
                seg_left--;
                sent++;
                // sender holds off until the block has drained
                if ($urandom_range(0, 59) == 0)
                    settle_block(0);
            end
        end
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
    endtask

    // ------------------------------------------------------------------
    // sequence
    // ------------------------------------------------------------------
    initial begin
        build_curve_table();
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_default_frames();
        test_lane_clamps();
        test_full_scale_negative();
        test_blend_extremes();
        test_pole_extremes();
        test_random_program();
        settle_block(SETTLE_CYCLES);
        $display("%0d frames sent, %0d results checked, %0d register settings, %0d mismatches",
                 frames_sent, results_checked, settings_used, mismatch_count);
        $display("lane counts 0 to 7, blend from zero past unity, poles at both ends");
        if (mismatch_count == 0 && expected_frames.size() == 0) begin
            $display("tb_top OK");
        end else begin
            $display("tb_top NOT OK");
        end
        $finish;
    end

    // hard stop if results stop coming
    initial begin
        #RUN_LIMIT_NS;
        $display("run stopped by timeout, %0d results pending", expected_frames.size());
        $display("tb_top NOT OK");
        $finish;
    end

endmodule

FILE: peak_envelope_curve_gain.f
+incdir+design
design/pecg_pkg.sv
design/peak_envelope_curve_gain.sv
tb/tb_top.sv
